>>> rtl/msc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the message slot carousel: payload structs,
// action and show-kind codes, register indexes, controller/datapath links.
// ----------------------------------------------------------------------------
package msc_pkg;

  // slot store geometry
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_SECONDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_CLOCK   = 1'd1;
  localparam logic [5:0]           FLIP_SECONDS_RST = 6'd4;

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_FREEZE = 2'd3;

  // show-kind codes
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CLOCK = 2'd1;
  localparam logic [1:0] KIND_BOOT  = 2'd2;

  // timing constants
  localparam logic [3:0]  TICK_WRAP   = 4'd10;
  localparam logic [31:0] FREEZE_STEP = 32'd100;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  slot_index;
    logic [15:0] slot_timeout;
    logic        has_text;
    logic [31:0] freeze_ms;
    logic [31:0] now_seconds;
  } msc_in_t;

  typedef struct packed {
    logic       update_done;
    logic [1:0] show_kind;
    logic [2:0] shown_slot;
    logic       frozen;
  } msc_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic second;
    logic boot;
    logic upd;
    logic scan;
    logic load_out;
  } msc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic second_due;
    logic clr_req;
    logic flip_go;
    logic clock_now;
    logic hit;
    logic scan_last;
  } msc_stat_t;

endpackage
`default_nettype wire

>>> rtl/msc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer of the carousel: walks one item through execute, one-second
// processing, display update and slot scan, and owns both handshakes.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire msc_pkg::msc_stat_t st,
  output msc_pkg::msc_cmd_t       cmd
);
  import msc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SECOND = 7'b0000100,
    S_BOOT   = 7'b0001000,
    S_UPD    = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.take     = in_valid && in_ready;
    cmd.exec     = (state == S_EXEC);
    cmd.second   = (state == S_SECOND);
    cmd.boot     = (state == S_BOOT);
    cmd.upd      = (state == S_UPD);
    cmd.scan     = (state == S_SCAN);
    cmd.load_out = (state == S_FINISH) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.second_due)   state_next = S_SECOND;
        else if (st.clr_req) state_next = S_UPD;
        else                 state_next = S_FINISH;
      end
      S_SECOND: state_next = S_BOOT;
      S_BOOT: begin
        state_next = st.flip_go ? S_UPD : S_FINISH;
      end
      S_UPD: begin
        state_next = st.clock_now ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (st.hit || st.scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/msc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msc_dp
// Datapath of the carousel: configuration registers, per-slot timers and
// flags, freeze countdown, tick divider, flip timing, slot scan and result.
// ----------------------------------------------------------------------------
module msc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire msc_pkg::msc_in_t                  in_data,
  output msc_pkg::msc_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [msc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [msc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire msc_pkg::msc_cmd_t                 cmd,
  output msc_pkg::msc_stat_t                     st
);
  import msc_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  msc_in_t            item;
  logic [5:0]         flip_seconds;
  logic               show_clock;
  logic [15:0]        slot_timer [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_boot;
  logic [SLOT_W-1:0]  current_slot;
  logic [31:0]        freeze_left;
  logic [3:0]         tick_divider;
  logic [31:0]        last_flip_time;
  logic               clock_shown;
  logic               upd_done;
  logic [1:0]         upd_kind;
  logic [SLOT_W-1:0]  scan_ptr;
  logic [SLOT_W-1:0]  scan_cnt;

  logic [31:0]        flip_limit;
  logic               flip_due;
  logic [SLOT_W-1:0]  next_slot;
  logic [SLOT_W-1:0]  scan_start;
  logic [SLOT_W-1:0]  scan_ptr_inc;

  // flip interval check
  assign flip_limit = last_flip_time + {26'd0, flip_seconds};
  assign flip_due   = (last_flip_time > item.now_seconds) ||
                      (flip_limit < item.now_seconds);

  // round-robin start point
  assign next_slot    = (current_slot == SLOT_LAST) ? '0 : current_slot + 1'b1;
  assign scan_start   = (item.action == ACT_TICK) ? next_slot : current_slot;
  assign scan_ptr_inc = (scan_ptr == SLOT_LAST) ? '0 : scan_ptr + 1'b1;

  // status to the controller
  always_comb begin
    st            = '0;
    st.second_due = (item.action == ACT_TICK) && (tick_divider == TICK_WRAP);
    st.clr_req    = (item.action == ACT_CLEAR);
    st.flip_go    = flip_due && (freeze_left == '0);
    st.clock_now  = show_clock && !clock_shown;
    st.hit        = slot_active[scan_ptr];
    st.scan_last  = (scan_cnt == SLOT_LAST);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_seconds <= FLIP_SECONDS_RST;
      show_clock   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLIP_SECONDS: flip_seconds <= cfg_data;
        REG_SHOW_CLOCK:   show_clock   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_data;
    if (cmd.load_out) begin
      out_data.update_done <= upd_done;
      out_data.show_kind   <= upd_kind;
      out_data.shown_slot  <= current_slot;
      out_data.frozen      <= (freeze_left != '0);
    end
  end

  // carousel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOT_COUNT; s++) slot_timer[s] <= '0;
      slot_active    <= '0;
      slot_boot      <= '0;
      current_slot   <= '0;
      freeze_left    <= '0;
      tick_divider   <= '0;
      last_flip_time <= '0;
      clock_shown    <= 1'b0;
      upd_done       <= 1'b0;
      upd_kind       <= KIND_TEXT;
      scan_ptr       <= '0;
      scan_cnt       <= '0;
    end else if (cmd.exec) begin
      upd_done <= 1'b0;
      upd_kind <= KIND_TEXT;
      unique case (item.action)
        ACT_TICK: begin
          // 100 ms off the freeze, divider counts eleven ticks
          if (freeze_left <= FREEZE_STEP) freeze_left <= '0;
          else                            freeze_left <= freeze_left - FREEZE_STEP;
          if (tick_divider == TICK_WRAP) tick_divider <= '0;
          else                           tick_divider <= tick_divider + 4'd1;
        end
        ACT_WRITE: begin
          if (int'(item.slot_index) < SLOT_COUNT) begin
            slot_active[SLOT_W'(item.slot_index)] <= item.has_text;
            slot_timer[SLOT_W'(item.slot_index)]  <= item.slot_timeout;
            slot_boot[SLOT_W'(item.slot_index)]   <= 1'b0;
          end
        end
        ACT_CLEAR: begin
          for (int s = 1; s < SLOT_COUNT; s++) slot_timer[s] <= '0;
          slot_timer[0] <= item.slot_timeout;
          slot_active   <= {{(SLOT_COUNT-1){1'b0}}, item.has_text};
          slot_boot     <= '0;
        end
        ACT_FREEZE: freeze_left <= item.freeze_ms;
        default: ;
      endcase
    end else if (cmd.second) begin
      // one second on every slot timer, expiring slots empty
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (slot_timer[s] == 16'd1) begin
          slot_active[s] <= 1'b0;
          slot_boot[s]   <= 1'b0;
        end
        if (slot_timer[s] != '0) slot_timer[s] <= slot_timer[s] - 16'd1;
      end
    end else if (cmd.boot) begin
      // boot message when nothing is left, then flip timing
      if (slot_active == '0) begin
        slot_timer[0]  <= 16'd1;
        slot_active[0] <= 1'b1;
        slot_boot[0]   <= 1'b1;
      end
      if (flip_due) last_flip_time <= item.now_seconds;
    end else if (cmd.upd) begin
      upd_done <= 1'b1;
      if (show_clock && !clock_shown) begin
        clock_shown <= 1'b1;
        upd_kind    <= KIND_CLOCK;
      end else begin
        if (show_clock) clock_shown <= 1'b0;
        scan_ptr <= scan_start;
        scan_cnt <= '0;
      end
    end else if (cmd.scan) begin
      // one slot per cycle, circular from the start point
      if (slot_active[scan_ptr]) begin
        current_slot <= scan_ptr;
        upd_kind     <= slot_boot[scan_ptr] ? KIND_BOOT : KIND_TEXT;
      end else if (scan_cnt == SLOT_LAST) begin
        current_slot <= '0;
        upd_kind     <= KIND_TEXT;
      end else begin
        scan_ptr <= scan_ptr_inc;
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/message_slot_carousel_top.sv
`default_nettype none
// Each item passes the execute state; a one-second tick then passes the second
// and boot states, and a tick that flips or a clear passes the update state and,
// unless the clock is shown, the slot scan; the result loads in the finish state.
// One item in flight: the next input transfer can come in the cycle after the
// result is loaded, so the scan sets the worst case. Reset (rst, synchronous):
// all slots empty, slot 0 current, flip interval 4, clock mode off, no result pending.
// ----------------------------------------------------------------------------
// message_slot_carousel_top
// Chooses which message slot a display shows: timers, freeze, round-robin
// flips and clock interleave, one result per input item.
// ----------------------------------------------------------------------------
module message_slot_carousel_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire msc_pkg::msc_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output msc_pkg::msc_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [msc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [msc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import msc_pkg::*;

  msc_cmd_t  cmd;
  msc_stat_t st;

  // sequencer
  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  msc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire

>>> rtl/msc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the carousel, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire msc_pkg::msc_out_t               out_data
);
  import msc_pkg::*;

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one item in flight: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken back to back");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // kind is a known code, and slot text when no update happened
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.show_kind == KIND_TEXT) ||
                   (out_data.update_done && (out_data.show_kind == KIND_CLOCK)) ||
                   (out_data.update_done && (out_data.show_kind == KIND_BOOT))))
    else $error("bad show kind");

endmodule

bind message_slot_carousel_top msc_checker u_msc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
